[rtl/core/multilevel_direct_mapped_writeback_cache_top_macros.svh]
// assertion macros for the multilevel cache tag store
`ifndef MULTILEVEL_DIRECT_MAPPED_WRITEBACK_CACHE_TOP_MACROS_SVH
`define MULTILEVEL_DIRECT_MAPPED_WRITEBACK_CACHE_TOP_MACROS_SVH

// checked only outside reset
`define MDMC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define MDMC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mdmc_pkg.sv]
// shared types and constants of the multilevel cache tag store
package mdmc_pkg;

  localparam int MAX_INDEX_BITS = 10;
  localparam int ADDRESS_BITS   = 32;
  localparam int LEVELS         = 3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_CACHE_KIND   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVELS_USED  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BITS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_INDEX  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_INDEX = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_THIRD_INDEX  = 3'd5;

  localparam logic [1:0] KIND_UNIFIED = 2'd0;
  localparam logic [1:0] KIND_INSTR   = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;

  localparam logic MODE_WRITE = 1'b1;

  localparam logic [1:0] HIT_NONE = 2'd3;

  typedef struct packed {
    logic        is_data;
    logic        mode;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] hit_level;
    logic [2:0] dirty_evictions;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic probe;
    logic write;
  } lvl_ctrl_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } lvl_stat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

[rtl/core/multilevel_direct_mapped_writeback_cache_top.sv]
// top level of the one- to three-level direct-mapped write-back cache tag store
//
// A reference word on req is taken at a clock edge with start high and busy
// low. All levels in use read their tag memory in that cycle; in the next
// cycle the levels are compared in order up to the first hit, every probed
// level writes its line back, and the result word appears on rsp with done
// high for exactly that one cycle. The receiver cannot stall the block.
// Each word is read and then written back in the same entry of each tag
// memory, so busy stays high in the result cycle and a new word can be taken
// only after the last one has been answered. Rejected references still pass
// through the lookup state and return a zero result.
// After reset a clearing pass writes every line of all three memories
// invalid and clean, one entry a cycle; busy is high meanwhile. Registers
// are written through cfg_write, cfg_index and cfg_data; the user must do so
// only while no word is in flight, which the block does not enforce. Reset
// restores their default values.
`include "multilevel_direct_mapped_writeback_cache_top_macros.svh"

module multilevel_direct_mapped_writeback_cache_top #(
  parameter int MAX_INDEX_BITS = mdmc_pkg::MAX_INDEX_BITS,
  parameter int ADDRESS_BITS   = mdmc_pkg::ADDRESS_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  mdmc_pkg::req_t                     req,
  output logic                               done,
  output mdmc_pkg::rsp_t                     rsp,
  input  logic                               cfg_write,
  input  logic [mdmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mdmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IW = MAX_INDEX_BITS;

  mdmc_pkg::state_t    state;
  mdmc_pkg::state_t    state_next;
  logic [IW-1:0]       clear_index;

  logic [1:0]          cache_kind;
  logic [1:0]          levels_used;
  logic [3:0]          offset_bits;
  logic [3:0]          index_bits [mdmc_pkg::LEVELS];

  logic                take;
  logic                kind_ok;
  logic                accepted;

  mdmc_pkg::lvl_ctrl_t ctrl [mdmc_pkg::LEVELS];
  mdmc_pkg::lvl_stat_t stat [mdmc_pkg::LEVELS];
  logic [2:0]          en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_kind    <= mdmc_pkg::KIND_UNIFIED;
      levels_used   <= 2'd1;
      offset_bits   <= 4'd4;
      index_bits[0] <= 4'd6;
      index_bits[1] <= 4'd8;
      index_bits[2] <= 4'd10;
    end else if (cfg_write) begin
      case (cfg_index)
        mdmc_pkg::REG_CACHE_KIND:   cache_kind    <= cfg_data[1:0];
        mdmc_pkg::REG_LEVELS_USED:  levels_used   <= cfg_data[1:0];
        mdmc_pkg::REG_OFFSET_BITS:  offset_bits   <= cfg_data;
        mdmc_pkg::REG_FIRST_INDEX:  index_bits[0] <= cfg_data;
        mdmc_pkg::REG_SECOND_INDEX: index_bits[1] <= cfg_data;
        mdmc_pkg::REG_THIRD_INDEX:  index_bits[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mdmc_pkg::ST_CLEAR;
      clear_index <= '0;
    end else begin
      state <= state_next;
      if (state == mdmc_pkg::ST_CLEAR) begin
        clear_index <= clear_index + IW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      mdmc_pkg::ST_CLEAR: begin
        if (&clear_index) begin
          state_next = mdmc_pkg::ST_IDLE;
        end
      end
      mdmc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = mdmc_pkg::ST_LOOKUP;
        end
      end
      mdmc_pkg::ST_LOOKUP: begin
        done       = 1'b1;
        state_next = mdmc_pkg::ST_IDLE;
      end
      default: state_next = mdmc_pkg::ST_CLEAR;
    endcase
  end

  assign take    = start && !busy;
  assign kind_ok = (cache_kind == mdmc_pkg::KIND_UNIFIED) ||
                   (cache_kind == mdmc_pkg::KIND_INSTR && !req.is_data) ||
                   (cache_kind == mdmc_pkg::KIND_DATA && req.is_data);

  always_ff @(posedge clk) begin
    if (take) begin
      accepted <= kind_ok;
    end
  end

  // probe in order until the first hit
  always_comb begin
    en[0] = done && accepted && (levels_used >= 2'd1);
    en[1] = en[0] && !stat[0].hit && (levels_used >= 2'd2);
    en[2] = en[1] && !stat[1].hit && (levels_used == 2'd3);
  end

  always_comb begin
    rsp = '0;
    if (accepted) begin
      rsp.accepted = 1'b1;
      if (en[0] && stat[0].hit) begin
        rsp.hit_level = 2'd0;
      end else if (en[1] && stat[1].hit) begin
        rsp.hit_level = 2'd1;
      end else if (en[2] && stat[2].hit) begin
        rsp.hit_level = 2'd2;
      end else begin
        rsp.hit_level = mdmc_pkg::HIT_NONE;
      end
      rsp.dirty_evictions = {en[2] && stat[2].evict,
                             en[1] && stat[1].evict,
                             en[0] && stat[0].evict};
    end
  end

  for (genvar g = 0; g < mdmc_pkg::LEVELS; g++) begin : g_level
    always_comb begin
      ctrl[g].clear = (state == mdmc_pkg::ST_CLEAR);
      ctrl[g].load  = take;
      ctrl[g].probe = en[g];
      ctrl[g].write = (req.mode == mdmc_pkg::MODE_WRITE);
    end

    mdmc_level #(
      .MAX_INDEX_BITS (MAX_INDEX_BITS),
      .ADDRESS_BITS   (ADDRESS_BITS)
    ) u_level (
      .clk         (clk),
      .ctrl        (ctrl[g]),
      .clear_index (clear_index),
      .addr        (req.address[ADDRESS_BITS-1:0]),
      .offset_bits (offset_bits),
      .index_bits  (index_bits[g]),
      .stat        (stat[g])
    );
  end

  `MDMC_ASSERT(a_take_then_done, take |=> done, "accepted word not answered next cycle")
  `MDMC_ASSERT(a_done_from_take, done |-> $past(take), "result word without accepted word")
  `MDMC_ASSERT(a_reject_zero,
    done && !rsp.accepted |-> rsp.hit_level == 2'd0 && rsp.dirty_evictions == 3'd0,
    "rejected word gave nonzero result")
  `MDMC_ASSERT(a_no_evict_past_hit,
    done && rsp.hit_level == 2'd0 |-> rsp.dirty_evictions[2:1] == 2'b00,
    "eviction reported below the hit level")
  `MDMC_ASSERT_ALWAYS(a_busy_after_reset, $past(rst) |-> busy, "not busy during clear")

endmodule

[rtl/core/mdmc_ram.sv]
// generic simple dual port ram with registered read
module mdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/mdmc_level.sv]
// one direct-mapped tag store level: address split, tag memory, compare and update
module mdmc_level #(
  parameter int MAX_INDEX_BITS = mdmc_pkg::MAX_INDEX_BITS,
  parameter int ADDRESS_BITS   = mdmc_pkg::ADDRESS_BITS
) (
  input  logic                      clk,
  input  mdmc_pkg::lvl_ctrl_t       ctrl,
  input  logic [MAX_INDEX_BITS-1:0] clear_index,
  input  logic [ADDRESS_BITS-1:0]   addr,
  input  logic [3:0]                offset_bits,
  input  logic [3:0]                index_bits,
  output mdmc_pkg::lvl_stat_t       stat
);

  localparam int IW = MAX_INDEX_BITS;
  localparam int SW = $clog2(MAX_INDEX_BITS + 1);
  localparam int EW = ADDRESS_BITS + 2;

  logic [ADDRESS_BITS-1:0] block;
  logic [SW-1:0]           ibits_sat;
  logic [IW-1:0]           index;
  logic [ADDRESS_BITS-1:0] tag;
  logic [IW-1:0]           index_q;
  logic [ADDRESS_BITS-1:0] tag_q;
  logic                    write_q;

  logic                    we;
  logic [IW-1:0]           waddr;
  logic [IW-1:0]           raddr;
  logic [EW-1:0]           wdata;
  logic [EW-1:0]           rdata;

  logic                    line_valid;
  logic                    line_dirty;
  logic [ADDRESS_BITS-1:0] line_tag;

  always_comb begin
    if (int'(offset_bits) < ADDRESS_BITS) begin
      block = addr >> offset_bits;
    end else begin
      block = '0;
    end
    if (int'(index_bits) > MAX_INDEX_BITS) begin
      ibits_sat = SW'(MAX_INDEX_BITS);
    end else begin
      ibits_sat = SW'(index_bits);
    end
    index = block[IW-1:0] & ~({IW{1'b1}} << ibits_sat);
    tag   = block >> ibits_sat;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      index_q <= index;
      tag_q   <= tag;
      write_q <= ctrl.write;
    end
  end

  assign line_valid = rdata[EW-1];
  assign line_dirty = rdata[EW-2];
  assign line_tag   = rdata[ADDRESS_BITS-1:0];

  assign stat.hit   = line_valid && (line_tag == tag_q);
  assign stat.evict = !stat.hit && line_dirty;

  always_comb begin
    we    = ctrl.clear || ctrl.probe;
    waddr = ctrl.clear ? clear_index : index_q;
    raddr = ctrl.clear ? clear_index : index;
    if (ctrl.clear) begin
      wdata = '0;
    end else begin
      wdata = {1'b1, stat.hit ? (line_dirty || write_q) : write_q, tag_q};
    end
  end

  mdmc_ram #(
    .WIDTH (EW),
    .DEPTH (2 ** MAX_INDEX_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

[tb/mdmc_tag_store_checker.sv]
// checker that predicts and compares every result word of the cache tag store
`timescale 1ns / 1ps

module mdmc_tag_store_checker
  import mdmc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  req_t                     req,
  input  logic                     done,
  input  rsp_t                     rsp,
  input  logic                     cfg_write,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       errors,
  output int                       outstanding
);

  localparam int LINE_COUNT = 1 << MAX_INDEX_BITS;

  typedef struct packed {
    logic [31:0] tag;
    logic        valid;
    logic        dirty;
  } line_t;

  line_t       lines [LEVELS][LINE_COUNT];
  logic [1:0]  kind_r;
  logic [1:0]  levels_r;
  logic [3:0]  offset_r;
  logic [3:0]  index_bits_r [LEVELS];

  rsp_t        pending_rsp [$];
  int          mismatch_count = 0;

  assign errors = mismatch_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic probe_level(input int lv, input logic [31:0] addr,
                                       input logic wr, output logic evicted);
    logic [3:0]                ib;
    logic [31:0]               block;
    logic [MAX_INDEX_BITS-1:0] idx;
    logic [31:0]               tag;
    ib = index_bits_r[lv];
    if (ib > MAX_INDEX_BITS) ib = 4'(MAX_INDEX_BITS);
    block = addr >> offset_r;
    idx = MAX_INDEX_BITS'(block & ((32'd1 << ib) - 32'd1));
    tag = block >> ib;
    evicted = 1'b0;
    if (lines[lv][idx].valid && lines[lv][idx].tag == tag) begin
      if (wr) lines[lv][idx].dirty = 1'b1;
      return 1'b1;
    end
    evicted = lines[lv][idx].dirty;
    lines[lv][idx].tag   = tag;
    lines[lv][idx].valid = 1'b1;
    lines[lv][idx].dirty = wr;
    return 1'b0;
  endfunction

  function automatic rsp_t cache_lookup(input req_t w);
    rsp_t r;
    logic ok;
    logic ev;
    r  = '0;
    ok = (kind_r == KIND_UNIFIED) || (kind_r == KIND_INSTR && !w.is_data) ||
         (kind_r == KIND_DATA && w.is_data);
    if (!ok) return r;
    r.accepted  = 1'b1;
    r.hit_level = HIT_NONE;
    for (int lv = 0; lv < LEVELS && lv < levels_r; lv++) begin
      if (probe_level(lv, w.address, w.mode == MODE_WRITE, ev)) begin
        if (ev) r.dirty_evictions[lv] = 1'b1;
        r.hit_level = lv[1:0];
        break;
      end
      if (ev) r.dirty_evictions[lv] = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int lv = 0; lv < LEVELS; lv++)
        for (int i = 0; i < LINE_COUNT; i++)
          lines[lv][i] = '0;
      kind_r          = KIND_UNIFIED;
      levels_r        = 2'd1;
      offset_r        = 4'd4;
      index_bits_r[0] = 4'd6;
      index_bits_r[1] = 4'd8;
      index_bits_r[2] = 4'd10;
      pending_rsp.delete();
    end else begin
      if (done) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected word", int'(rsp), 0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.accepted !== want.accepted)
            report_mismatch("accepted", int'(rsp.accepted), int'(want.accepted));
          if (rsp.hit_level !== want.hit_level)
            report_mismatch("hit_level", int'(rsp.hit_level), int'(want.hit_level));
          if (rsp.dirty_evictions !== want.dirty_evictions)
            report_mismatch("dirty_evictions", int'(rsp.dirty_evictions),
                            int'(want.dirty_evictions));
        end
      end
      // a word taken at this edge still sees the old register values
      if (start && !busy)
        pending_rsp.push_back(cache_lookup(req));
      if (cfg_write) begin
        case (cfg_index)
          REG_CACHE_KIND:   kind_r          = cfg_data[1:0];
          REG_LEVELS_USED:  levels_r        = cfg_data[1:0];
          REG_OFFSET_BITS:  offset_r        = cfg_data;
          REG_FIRST_INDEX:  index_bits_r[0] = cfg_data;
          REG_SECOND_INDEX: index_bits_r[1] = cfg_data;
          REG_THIRD_INDEX:  index_bits_r[2] = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_rsp.size();
  end

endmodule

[tb/tb_multilevel_direct_mapped_writeback_cache_top.sv]
// testbench top for the multilevel direct-mapped write-back cache tag store
`timescale 1ns / 1ps

module tb_multilevel_direct_mapped_writeback_cache_top;
  import mdmc_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 62;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  req_t                    req;
  logic                    done;
  rsp_t                    rsp;
  logic                    cfg_write;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  int                      errors;
  int                      outstanding;

  int                      idle_pct;
  logic [31:0]             hi_pool [4];
  logic [31:0]             lo_pool [4];

  multilevel_direct_mapped_writeback_cache_top uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mdmc_tag_store_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_word(input logic is_data, input logic wr, input logic [31:0] addr);
    req_t w;
    w.is_data = is_data;
    w.mode    = wr;
    w.address = addr;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_config(input logic [3:0] kind, input logic [3:0] lv, input logic [3:0] off,
                            input logic [3:0] i0, input logic [3:0] i1, input logic [3:0] i2);
    wait_drain();
    write_reg(REG_CACHE_KIND, kind);
    write_reg(REG_LEVELS_USED, lv);
    write_reg(REG_OFFSET_BITS, off);
    write_reg(REG_FIRST_INDEX, i0);
    write_reg(REG_SECOND_INDEX, i1);
    write_reg(REG_THIRD_INDEX, i2);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [3:0] pick_index_bits();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(11, 15));
    return 4'($urandom_range(0, 7));
  endfunction

  initial begin
    logic [3:0]  kind;
    logic [3:0]  lv;
    logic [3:0]  off;
    logic [31:0] addr;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: unified, one level
    send_word(1'b1, 1'b0, 32'h0000_0000);
    send_word(1'b0, 1'b0, 32'h0000_000F);
    send_word(1'b1, MODE_WRITE, 32'h0000_0000);
    send_word(1'b1, 1'b0, 32'h0000_0400);
    send_word(1'b1, MODE_WRITE, 32'hFFFF_FFFF);
    send_word(1'b0, 1'b0, 32'hFFFF_FFFF);

    set_config({2'b00, KIND_UNIFIED}, 4'd3, 4'd2, 4'd0, 4'd10, 4'd15);
    send_word(1'b1, MODE_WRITE, 32'h1234_5678);
    send_word(1'b1, 1'b0, 32'h1234_5678);
    send_word(1'b1, 1'b0, 32'h8765_4321);
    send_word(1'b0, MODE_WRITE, 32'h1234_5678);
    send_word(1'b1, 1'b0, 32'h8765_4321);

    set_config({2'b00, KIND_INSTR}, 4'd2, 4'd8, 4'd10, 4'd0, 4'd0);
    send_word(1'b1, 1'b0, 32'h0000_1000);
    send_word(1'b0, MODE_WRITE, 32'hAAAA_AAAA);
    send_word(1'b0, 1'b0, 32'h5555_5555);
    send_word(1'b0, 1'b0, 32'hAAAA_AAAA);

    set_config({2'b00, KIND_DATA}, 4'd3, 4'd4, 4'd1, 4'd2, 4'd3);
    send_word(1'b0, 1'b0, 32'h0000_0010);
    send_word(1'b1, MODE_WRITE, 32'h0000_0010);
    send_word(1'b1, MODE_WRITE, 32'h0000_0050);

    set_config({2'b00, KIND_NONE}, 4'd1, 4'd4, 4'd6, 4'd8, 4'd10);
    send_word(1'b0, 1'b0, 32'h0000_0020);
    send_word(1'b1, MODE_WRITE, 32'h0000_0020);

    // unused register indexes are ignored
    wait_drain();
    write_reg(3'd6, 4'hF);
    write_reg(3'd7, 4'hA);
    @(negedge clk);
    cfg_write <= 1'b0;

    set_config({2'b11, KIND_UNIFIED}, 4'd0, 4'd15, 4'd15, 4'd15, 4'd15);
    send_word(1'b1, MODE_WRITE, 32'hDEAD_BEEF);
    send_word(1'b0, 1'b0, 32'hDEAD_BEEF);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        set_config({2'b00, KIND_UNIFIED}, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0);
      end else if (ph == 1) begin
        set_config({2'b00, KIND_UNIFIED}, 4'd3, 4'd8, 4'd10, 4'd10, 4'd10);
      end else begin
        kind = ($urandom_range(0, 9) < 5) ? {2'b00, KIND_UNIFIED} : 4'($urandom_range(0, 15));
        lv   = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 3));
        off  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(2, 8));
        set_config(kind, lv, off, pick_index_bits(), pick_index_bits(), pick_index_bits());
      end
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 72;
        default: idle_pct = 24;
      endcase
      for (int i = 0; i < 4; i++) begin
        hi_pool[i] = $urandom();
        lo_pool[i] = $urandom();
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ((ph == 2 && n == 30) || $urandom_range(0, 49) == 0)
          wait_drain();
        if ($urandom_range(0, 4) == 0)
          addr = $urandom();
        else
          addr = (hi_pool[$urandom_range(0, 3)] & 32'hFFFF_F000) |
                 (lo_pool[$urandom_range(0, 3)] & 32'h0000_0FFF);
        send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), addr);
      end
    end

    wait_drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
